// ----- sv/upd_pkg.sv -----
// Shared types, character constants and hex helpers for the URL percent decoder.
// Used by the front classifier, the group queue and the output sequencer.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // At most three decoded bytes come out of one input byte.
    localparam int unsigned GROUP_MAX = 3;

    // Decoded bytes caused by one input byte; cnt is 1..3 when queued.
    typedef struct packed {
        logic [1:0]                 cnt;
        logic [GROUP_MAX-1:0][7:0]  bytes;
        logic                       last;
    } upd_group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Valid only for hex digit characters; letters of either case map to 10..15.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        if (c[6])
        begin
            v = c[3:0] + 4'd9;
        end
        else
        begin
            v = c[3:0];
        end
        return v;
    endfunction

endpackage

// ----- sv/upd_in_if.sv -----
// Input channel of the URL percent decoder: one encoded byte per transfer.
// No dependencies.
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- sv/upd_out_if.sv -----
// Output channel of the URL percent decoder: one decoded byte per transfer.
// No dependencies.
interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- sv/upd_front.sv -----
// Front end: accepts encoded bytes, tracks the escape state, builds result groups.
// Depends on upd_pkg and upd_in_if.
module upd_front (
    input  logic                clk,
    input  logic                rst_n,
    upd_in_if.sink              enc,
    input  logic                full,
    output logic                push,
    output upd_pkg::upd_group_t grp
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_DIGIT   = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;
    logic       consumed;
    logic       b_hex;

    function automatic upd_pkg::upd_group_t put(input upd_pkg::upd_group_t g,
                                                input logic [7:0] b);
        upd_pkg::upd_group_t r;
        r = g;
        if (r.cnt != 2'd3)
        begin
            r.bytes[r.cnt] = b;
            r.cnt          = r.cnt + 2'd1;
        end
        return r;
    endfunction

    assign enc.ready = !full;
    assign accept    = enc.valid && !full;
    assign b_hex     = upd_pkg::is_hex(enc.in_byte);

    always_comb
    begin
        grp        = '0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        consumed   = 1'b0;

        case (phase_reg)
            PH_PERCENT:
            begin
                if (b_hex)
                begin
                    held_next  = enc.in_byte;
                    phase_next = PH_DIGIT;
                    consumed   = 1'b1;
                end
                else
                begin
                    grp = put(grp, upd_pkg::CH_PERCENT);
                end
            end
            PH_DIGIT:
            begin
                if (b_hex)
                begin
                    grp = put(grp, {upd_pkg::hex_nibble(held_reg),
                                    upd_pkg::hex_nibble(enc.in_byte)});
                    consumed = 1'b1;
                end
                else
                begin
                    grp = put(grp, upd_pkg::CH_PERCENT);
                    grp = put(grp, held_reg);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (!consumed)
        begin
            if (enc.in_byte == upd_pkg::CH_PERCENT)
            begin
                phase_next = PH_PERCENT;
            end
            else if (enc.in_byte == upd_pkg::CH_PLUS)
            begin
                grp = put(grp, upd_pkg::CH_SPACE);
            end
            else
            begin
                grp = put(grp, enc.in_byte);
            end
        end

        // End of string: flush whatever escape is still pending.
        if (enc.in_last)
        begin
            if (phase_next == PH_PERCENT)
            begin
                grp = put(grp, upd_pkg::CH_PERCENT);
            end
            else if (phase_next == PH_DIGIT)
            begin
                grp = put(grp, upd_pkg::CH_PERCENT);
                grp = put(grp, held_next);
            end
            phase_next = PH_IDLE;
        end
        grp.last = enc.in_last;
    end

    assign push = accept && (grp.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ----- sv/upd_queue.sv -----
// Small FIFO of result groups between the front end and the output sequencer.
// Depends on upd_pkg.
module upd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  upd_pkg::upd_group_t wr_grp,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output upd_pkg::upd_group_t head_grp
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    upd_pkg::upd_group_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_grp   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

// ----- sv/upd_back.sv -----
// Back end: walks the head group one byte per transfer, pops it after its final byte.
// Depends on upd_pkg and upd_out_if.
module upd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  upd_pkg::upd_group_t head_grp,
    output logic                pop,
    upd_out_if.source           dec
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       at_end;
    logic       xfer;

    assign at_end       = (idx_reg == (head_grp.cnt - 2'd1));
    assign xfer         = head_valid && dec.ready;
    assign pop          = xfer && at_end;

    assign dec.valid    = head_valid;
    assign dec.out_byte = head_grp.bytes[idx_reg];
    assign dec.out_last = head_grp.last && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = 2'd0;
        end
        else if (xfer)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ----- sv/url_percent_decoder.sv -----
// Streaming URL percent decoder. A result group is registered in the group queue and
// offered from its head. Throughput: one input byte per cycle while each yields at
// most one byte and the output stays ready; a byte that yields a group of two or
// three takes one output transfer per byte, and the group queue (QDEPTH groups)
// absorbs the burst. Reset: asynchronous, active low; clears the escape state, the
// queue and the output byte index. No configuration and no clearing pass.
module url_percent_decoder #(
    parameter int unsigned QDEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    upd_in_if.sink    enc,
    upd_out_if.source dec
);

    // Front end classifies each byte and pushes the group of results it causes.
    upd_pkg::upd_group_t wr_grp;
    upd_pkg::upd_group_t head_grp;
    logic                push;
    logic                full;
    logic                pop;
    logic                head_valid;

    upd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc),
        .full  (full),
        .push  (push),
        .grp   (wr_grp)
    );

    // Groups wait here so input transfers keep going while the output stalls.
    upd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_grp     (wr_grp),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_grp   (head_grp)
    );

    // Back end serializes the head group onto the output channel.
    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_grp   (head_grp),
        .pop        (pop),
        .dec        (dec)
    );

endmodule
